// ----- design/heartbeat_sequence_monitor_defines.svh -----
// Assertion macros shared by the heartbeat monitor design files.
// Depends on nothing; the including module must provide clk and rst.
`ifndef HEARTBEAT_SEQUENCE_MONITOR_DEFINES_SVH
`define HEARTBEAT_SEQUENCE_MONITOR_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define HBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heartbeat monitor: same-cycle check failed");

// Condition implies consequence in the following cycle.
`define HBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heartbeat monitor: next-cycle check failed");

`endif

// ----- design/hbm_pkg.sv -----
// Shared constants, codes and beat types for the heartbeat monitor.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hbm_pkg;

  localparam int ID_W        = 22;
  localparam int SEQ_W       = 32;
  localparam int SLOT_W      = 4;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int ACTIVE_W    = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam int SLOTS_DEFAULT = 16;
  localparam int USE_LIMIT     = 16;

  localparam logic [SEQ_W-1:0]    TIMEOUT_RESET = 32'd1000;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET  = 5'd16;

  localparam logic [KIND_W-1:0] KIND_MSG    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GAP     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 1'd1;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [ID_W-1:0]          sender_id;
    logic signed [SEQ_W-1:0]  seq_number;
    logic [SLOT_W-1:0]        slot_index;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [SLOT_W-1:0]        slot_out;
    logic [ID_W-1:0]          id_out;
    logic signed [SEQ_W-1:0]  missing_count;
    logic                     last_of_run;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  sender;
    logic [SEQ_W-1:0] last_seq;
    logic [SEQ_W-1:0] count;
  } slot_entry_t;

  typedef struct packed {
    logic             en;
    logic             valid;
    logic             sender_en;
    logic [ID_W-1:0]  sender;
    logic             seq_en;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] count;
  } slot_write_t;

  typedef struct packed {
    logic             hit;
    logic             nonzero;
    logic [SEQ_W-1:0] value;
  } unit_result_t;

endpackage

`default_nettype wire

// ----- design/hbm_slot_unit.sv -----
// Shared per-slot arithmetic: one adder serves both kinds.
// Depends on hbm_pkg.
`default_nettype none

module hbm_slot_unit (
  input  wire logic [hbm_pkg::KIND_W-1:0] kind,
  input  wire logic [hbm_pkg::ID_W-1:0]   sender_id,
  input  wire logic [hbm_pkg::SEQ_W-1:0]  seq,
  input  wire logic [hbm_pkg::SEQ_W-1:0]  timeout,
  input  wire hbm_pkg::slot_entry_t       entry,
  output hbm_pkg::unit_result_t           res
);
  import hbm_pkg::*;

  logic             is_msg;
  logic [SEQ_W-1:0] op_a;
  logic [SEQ_W-1:0] op_b;
  logic [SEQ_W-1:0] sum;
  logic             saturated;

  // Messages compute seq + ~last, which is seq - last - 1 modulo 2^32.
  // Ticks compute count + 1.
  assign is_msg    = (kind == KIND_MSG);
  assign op_a      = is_msg ? seq : entry.count;
  assign op_b      = is_msg ? ~entry.last_seq : '0;
  assign sum       = op_a + op_b + {{(SEQ_W-1){1'b0}}, ~is_msg};
  assign saturated = &entry.count;

  always_comb begin
    res.nonzero = (sum != '0);
    if (is_msg) begin
      res.value = sum;
      res.hit   = entry.valid && (entry.sender == sender_id);
    end else begin
      res.value = saturated ? entry.count : sum;
      res.hit   = entry.valid && (res.value > timeout);
    end
  end

endmodule

`default_nettype wire

// ----- design/hbm_slot_store.sv -----
// Per-slot state: valid flags, bound sender ids, sequence numbers and
// silence counters, with one write port and one read port. Depends on hbm_pkg.
`default_nettype none

module hbm_slot_store #(
  parameter int SLOTS = hbm_pkg::SLOTS_DEFAULT,
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] rd_addr,
  output hbm_pkg::slot_entry_t  rd_entry,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire hbm_pkg::slot_write_t wr
);
  import hbm_pkg::*;

  logic             valid    [SLOTS];
  logic [ID_W-1:0]  sender   [SLOTS];
  logic [SEQ_W-1:0] last_seq [SLOTS];
  logic [SEQ_W-1:0] count    [SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (wr.en) begin
      valid[wr_addr] <= wr.valid;
    end
  end

  // Sequence numbers and counters are always written on binding, so they
  // need no reset.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      count[wr_addr] <= wr.count;
      if (wr.sender_en) begin
        sender[wr_addr] <= wr.sender;
      end
      if (wr.seq_en) begin
        last_seq[wr_addr] <= wr.seq;
      end
    end
  end

  assign rd_entry.valid    = valid[rd_addr];
  assign rd_entry.sender   = sender[rd_addr];
  assign rd_entry.last_seq = last_seq[rd_addr];
  assign rd_entry.count    = count[rd_addr];

endmodule

`default_nettype wire

// ----- design/heartbeat_sequence_monitor.sv -----
// Top level of the multi-slot heartbeat monitor: sequencer, configuration
// registers, pending and output registers. Depends on hbm_pkg, hbm_slot_unit,
// hbm_slot_store and heartbeat_sequence_monitor_defines.svh.
//
//   Channel   Direction  Handshake                 Beat
//   item      in         item_valid / item_stall   hbm_pkg::item_t
//   result    out        result_valid / result_stall hbm_pkg::result_t
//   cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An assign beat is taken without a scan. A message or tick beat starts a scan that
// visits one slot in use per cycle through the shared slot unit, unless a full,
// stalled result register holds it, and stalls the item channel until the scan ends;
// the slots in use number at most 16. A message stops at its first matching slot.
// The result register lets a new item beat in while a result waits. Synchronous reset
// clears valid flags, sequencer and valid bits and loads the configuration defaults.
`default_nettype none

module heartbeat_sequence_monitor #(
  parameter int SLOTS = hbm_pkg::SLOTS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire hbm_pkg::item_t                  item,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output hbm_pkg::result_t                     result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hbm_pkg::*;

`include "heartbeat_sequence_monitor_defines.svh"

  // Only the first sixteen slots can ever be in use or bound, so the store
  // holds no more than that.
  localparam int USE_MAX = (SLOTS < USE_LIMIT) ? SLOTS : USE_LIMIT;
  localparam int IDX_W   = (USE_MAX > 1) ? $clog2(USE_MAX) : 1;
  localparam int CNT_W   = $clog2(USE_MAX + 1);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_SCAN = 1'b1;

  // Sequencer and item registers.
  logic [0:0]              state;
  logic [0:0]              state_next;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        idx_next;
  logic [KIND_W-1:0]       cur_kind;
  logic [ID_W-1:0]         cur_id;
  logic [SEQ_W-1:0]        cur_seq;

  // A timeout found by the tick scan waits here until the scan knows whether
  // it is the last one, so that last_of_run can be set correctly.
  logic                    pend_valid;
  logic                    pend_valid_next;
  result_t                 pend;
  result_t                 pend_next;

  logic                    result_valid_next;
  result_t                 result_next;

  // Configuration registers.
  logic [SEQ_W-1:0]        timeout_ticks;
  logic [ACTIVE_W-1:0]     active_slots;

  logic [CNT_W-1:0]        use_n;
  logic                    item_accept;
  logic                    out_free;
  logic                    scan_end;

  slot_entry_t             entry;
  unit_result_t            unit_res;
  slot_write_t             wr;
  logic [IDX_W-1:0]        wr_addr;
  result_t                 hit_result;

  assign cfg_ready   = 1'b1;
  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign out_free    = !result_valid || !result_stall;

  assign use_n    = (32'(active_slots) >= USE_MAX) ? CNT_W'(USE_MAX) : CNT_W'(active_slots);
  assign scan_end = (idx >= use_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      active_slots  <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMEOUT: timeout_ticks <= cfg_data;
        REG_ACTIVE:  active_slots  <= cfg_data[ACTIVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hbm_slot_store #(
    .SLOTS (USE_MAX),
    .IDX_W (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (idx[IDX_W-1:0]),
    .rd_entry (entry),
    .wr_addr  (wr_addr),
    .wr       (wr)
  );

  hbm_slot_unit u_unit (
    .kind      (cur_kind),
    .sender_id (cur_id),
    .seq       (cur_seq),
    .timeout   (timeout_ticks),
    .entry     (entry),
    .res       (unit_res)
  );

  // The result a matching slot gives: a sequence report for a message,
  // a timeout report for a tick.
  always_comb begin
    hit_result.slot_out    = SLOT_W'(idx);
    hit_result.id_out      = entry.sender;
    hit_result.last_of_run = 1'b0;
    if (cur_kind == KIND_MSG) begin
      hit_result.status        = unit_res.nonzero ? ST_GAP : ST_OK;
      hit_result.missing_count = unit_res.value;
      hit_result.last_of_run   = 1'b1;
    end else begin
      hit_result.status        = ST_TIMEOUT;
      hit_result.missing_count = '0;
    end
  end

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    pend_valid_next   = pend_valid;
    pend_next         = pend;
    result_valid_next = result_valid && result_stall;
    result_next       = result;
    wr                = '0;
    wr_addr           = idx[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (item_accept) begin
          case (item.kind)
            KIND_MSG, KIND_TICK: begin
              state_next = S_SCAN;
              idx_next   = '0;
            end
            KIND_ASSIGN: begin
              // Binding resets the slot's sequence number and counter.
              wr_addr      = IDX_W'(item.slot_index);
              wr.en        = (32'(item.slot_index) < SLOTS);
              wr.valid     = 1'b1;
              wr.sender_en = 1'b1;
              wr.sender    = item.sender_id;
              wr.seq_en    = 1'b1;
              wr.seq       = '0;
              wr.count     = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_end) begin
          if (cur_kind == KIND_MSG) begin
            // No bound slot matched: the sender is unknown.
            if (out_free) begin
              result_valid_next         = 1'b1;
              result_next.status        = ST_UNKNOWN;
              result_next.slot_out      = '0;
              result_next.id_out        = cur_id;
              result_next.missing_count = '0;
              result_next.last_of_run   = 1'b1;
              state_next                = S_IDLE;
            end
          end else if (pend_valid) begin
            if (out_free) begin
              result_valid_next       = 1'b1;
              result_next             = pend;
              result_next.last_of_run = 1'b1;
              pend_valid_next         = 1'b0;
              state_next              = S_IDLE;
            end
          end else begin
            state_next = S_IDLE;
          end
        end else if (cur_kind == KIND_MSG) begin
          if (!unit_res.hit) begin
            idx_next = idx + 1'b1;
          end else if (out_free) begin
            result_valid_next = 1'b1;
            result_next       = hit_result;
            wr.en             = 1'b1;
            wr.valid          = 1'b1;
            wr.seq_en         = 1'b1;
            wr.seq            = cur_seq;
            wr.count          = '0;
            state_next        = S_IDLE;
          end
        end else if (!(unit_res.hit && pend_valid && !out_free)) begin
          // Tick: advance the counter, or retire the slot on a timeout.
          wr.en     = 1'b1;
          wr.valid  = entry.valid && !unit_res.hit;
          wr.seq_en = unit_res.hit;
          wr.seq    = '0;
          wr.count  = unit_res.hit ? '0 : unit_res.value;
          idx_next  = idx + 1'b1;
          if (unit_res.hit) begin
            if (pend_valid) begin
              result_valid_next = 1'b1;
              result_next       = pend;
            end
            pend_valid_next = 1'b1;
            pend_next       = hit_result;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      idx          <= idx_next;
      pend_valid   <= pend_valid_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend   <= pend_next;
    result <= result_next;
    if (item_accept) begin
      cur_kind <= item.kind;
      cur_id   <= item.sender_id;
      cur_seq  <= item.seq_number;
    end
  end

  // A held timeout only exists during a tick scan.
  `HBM_ASSERT_NOW(a_pend_in_tick, pend_valid, (state == S_SCAN) && (cur_kind == KIND_TICK))
  // Held results are always timeouts.
  `HBM_ASSERT_NOW(a_pend_status, pend_valid, pend.status == ST_TIMEOUT)
  // The scan never runs past the slots in use.
  `HBM_ASSERT_NOW(a_idx_bound, state == S_SCAN, idx <= use_n)
  // A finished message scan always leaves its single result, marked last.
  `HBM_ASSERT_NEXT(a_msg_result,
    (state == S_SCAN) && (state_next == S_IDLE) && (cur_kind == KIND_MSG),
    result_valid && result.last_of_run)

endmodule

`default_nettype wire
